### rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared constants, types and helpers of the stereo ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  // Store geometry; the depth is a power of two so positions wrap by truncation
  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int MAX_BURST = 64;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int OFFSET_W = 12;
  localparam int COUNT_W  = 7;
  localparam int ACTION_W = 3;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int FRAC_W   = 20;
  localparam int WIDE_W   = PROD_W + 1 - FRAC_W;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SCALE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ENCODE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DECODE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_MOVE   = 3'd5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One stored frame as it sits in memory
  typedef struct packed {
    sample_t right;
    sample_t left;
  } frame_t;

  // One result frame waiting in the output queue
  typedef struct packed {
    logic    last;
    sample_t right;
    sample_t left;
  } out_item_t;

  // Control handed to the arithmetic unit for a read-modify-write request
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                channel;
    sample_t             factor;
  } alu_ctl_t;

  // Clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    lo = WIDE_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (v > hi) begin
      sat_sample = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_sample = lo[SAMPLE_W-1:0];
    end else begin
      sat_sample = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram
// Single-port frame memory, one registered read per cycle when not writing.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_ram
  import srb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire frame_t            wdata,
  output frame_t                 rdata
);

  frame_t mem [DEPTH];
  frame_t rdata_r;

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/srb_alu.sv
// ----------------------------------------------------------------------------
// srb_alu
// Frame arithmetic: scale with rounding and saturation, mid-side encode and
// decode. The multiply is registered before rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_alu
  import srb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     load,
  input  wire alu_ctl_t ctl,
  input  wire frame_t   frame_in,
  output frame_t        frame_out
);

  alu_ctl_t                   ctl_r;
  frame_t                     frame_r;
  logic signed [PROD_W-1:0]   prod_r;

  sample_t                    pick;
  logic signed [PROD_W:0]     rounded;
  logic signed [WIDE_W-1:0]   scaled;
  sample_t                    scaled_sat;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   diff;

  assign pick = ctl.channel ? frame_in.left : frame_in.right;

  // Capture operands and the raw product
  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r   <= ctl;
      frame_r <= frame_in;
      prod_r  <= pick * ctl.factor;
    end
  end

  // Round half up, drop the fraction, saturate
  always_comb begin
    rounded    = (PROD_W+1)'(prod_r) + (PROD_W+1)'(1 << (FRAC_W - 1));
    scaled     = rounded[PROD_W:FRAC_W];
    scaled_sat = sat_sample(scaled);
    sum        = (SAMPLE_W+1)'(frame_r.left) + (SAMPLE_W+1)'(frame_r.right);
    diff       = (SAMPLE_W+1)'(frame_r.left) - (SAMPLE_W+1)'(frame_r.right);
  end

  // Select the rewritten frame
  always_comb begin
    frame_out = frame_r;
    unique case (ctl_r.action)
      ACT_SCALE: begin
        if (ctl_r.channel) begin
          frame_out.left = scaled_sat;
        end else begin
          frame_out.right = scaled_sat;
        end
      end
      ACT_ENCODE: begin
        frame_out.left  = sum[SAMPLE_W:1];
        frame_out.right = diff[SAMPLE_W:1];
      end
      ACT_DECODE: begin
        frame_out.left  = sat_sample(WIDE_W'(sum));
        frame_out.right = sat_sample(WIDE_W'(diff));
      end
      default: begin
        frame_out = frame_r;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/srb_outq.sv
// ----------------------------------------------------------------------------
// srb_outq
// Two-entry result queue between the memory read port and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_outq
  import srb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic [1:0]     level,
  output logic           head_valid,
  input  wire logic      head_ready,
  output out_item_t      head_item
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  out_item_t  e0_r;
  out_item_t  e0_nxt;
  out_item_t  e1_r;
  out_item_t  e1_nxt;
  logic       pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = e0_r;
  assign level      = cnt_r;
  assign pop        = head_valid && head_ready;

  // Shift on pop, fill the first free slot on push
  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    priority if (push && pop) begin
      if (cnt_r == 2'd1) begin
        e0_nxt = push_item;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push_item;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push_item;
      end else begin
        e1_nxt = push_item;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

`default_nettype wire

### rtl/stereo_ring_buffer_mid_side_top.sv
// ----------------------------------------------------------------------------
// stereo_ring_buffer_mid_side_top
// Stereo ring buffer with in-place scale and mid-side conversion.
//
//   channel  direction  payload                                 last
//   in_      slave      tuser action, tdata frame and operands  -
//   out_     master     tdata left/right frame                  tlast
//
// Write and move requests are carried out as they are accepted. Scale,
// encode and decode read the frame, capture it with the multiply, then
// write it back through the one memory port. During a read request the
// memory port issues one frame read a cycle while the two-entry result
// queue has room. After reset a clearing pass writes zero to all 1024
// entries, one per cycle; in_tready stays low until the pass ends.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_ring_buffer_mid_side_top
  import srb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [ACTION_W-1:0] in_tuser,  // action
  // offset[11:0], count[18:12], left_sample[42:19], right_sample[66:43],
  // factor[90:67], channel[91], zero pad[95:92]
  input  wire logic [95:0]         in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [47:0]              out_tdata, // left_out[23:0], right_out[47:24]
  output logic                     out_tlast
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;

  // Unpacked request fields
  logic signed [OFFSET_W-1:0] f_offset;
  logic [COUNT_W-1:0]         f_count;
  sample_t                    f_left;
  sample_t                    f_right;
  sample_t                    f_factor;
  logic                       f_channel;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [ADDR_W-1:0]  rp_r, rp_nxt;
  logic [ADDR_W-1:0]  wp_r, wp_nxt;
  logic [ADDR_W-1:0]  here_r, here_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [COUNT_W-1:0] remain_r, remain_nxt;
  logic               inflight_r, inflight_nxt;
  logic               inlast_r, inlast_nxt;
  alu_ctl_t           op_r, op_nxt;

  logic               accept;
  logic [ADDR_W-1:0]  here;
  logic [COUNT_W-1:0] burst;
  logic               issue;
  logic               pop;
  logic [1:0]         q_level;
  logic               alu_load;
  alu_ctl_t           alu_ctl;
  frame_t             alu_frame;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  frame_t             mem_wdata;
  frame_t             mem_rdata;

  out_item_t          q_push_item;
  out_item_t          q_head;

  assign f_offset  = in_tdata[11:0];
  assign f_count   = in_tdata[18:12];
  assign f_left    = in_tdata[42:19];
  assign f_right   = in_tdata[66:43];
  assign f_factor  = in_tdata[90:67];
  assign f_channel = in_tdata[91];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Position arithmetic wraps by truncation to the address width
  assign here  = rp_r + ADDR_W'(f_offset);
  assign burst = (f_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : f_count;

  // Issue a frame read only when the queue will have room for it
  assign pop   = out_tvalid && out_tready;
  assign issue = (state_r == ST_READ) && (remain_r != '0) &&
                 (({1'b0, q_level} + {2'b00, inflight_r}) < (3'd2 + {2'b00, pop}));

  // Hand the held request operands to the arithmetic unit
  assign alu_ctl  = op_r;
  assign alu_load = (state_r == ST_LOAD);

  // Sequencer and memory port steering
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    here_nxt     = here_r;
    rd_addr_nxt  = rd_addr_r;
    remain_nxt   = remain_r;
    op_nxt       = op_r;
    inflight_nxt = issue;
    inlast_nxt   = issue && (remain_r == COUNT_W'(1));
    mem_we       = 1'b0;
    mem_addr     = rd_addr_r;
    mem_wdata    = alu_frame;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = here;
        if (accept) begin
          unique case (in_tuser)
            ACT_WRITE: begin
              mem_we          = 1'b1;
              mem_addr        = wp_r;
              mem_wdata.left  = f_left;
              mem_wdata.right = f_right;
              wp_nxt          = wp_r + ADDR_W'(1);
            end
            ACT_READ: begin
              rd_addr_nxt = here;
              remain_nxt  = burst;
              if (burst != '0) begin
                state_nxt = ST_READ;
              end
            end
            ACT_SCALE, ACT_ENCODE, ACT_DECODE: begin
              here_nxt       = here;
              op_nxt.action  = in_tuser;
              op_nxt.channel = f_channel;
              op_nxt.factor  = f_factor;
              state_nxt      = ST_LOAD;
            end
            ACT_MOVE: begin
              rp_nxt = here;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        mem_addr = rd_addr_r;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + ADDR_W'(1);
          remain_nxt  = remain_r - COUNT_W'(1);
          if (remain_r == COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        mem_addr  = here_r;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        mem_we    = 1'b1;
        mem_addr  = here_r;
        mem_wdata = alu_frame;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      rp_r       <= '0;
      wp_r       <= '0;
      remain_r   <= '0;
      inflight_r <= 1'b0;
      inlast_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      remain_r   <= remain_nxt;
      inflight_r <= inflight_nxt;
      inlast_r   <= inlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    here_r    <= here_nxt;
    rd_addr_r <= rd_addr_nxt;
    op_r      <= op_nxt;
  end

  srb_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  srb_alu u_alu (
    .clk       (clk),
    .load      (alu_load),
    .ctl       (alu_ctl),
    .frame_in  (mem_rdata),
    .frame_out (alu_frame)
  );

  // Queue each returning burst frame
  assign q_push_item.last  = inlast_r;
  assign q_push_item.left  = mem_rdata.left;
  assign q_push_item.right = mem_rdata.right;

  srb_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (inflight_r),
    .push_item  (q_push_item),
    .level      (q_level),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head_item  (q_head)
  );

  assign out_tdata = {q_head.right, q_head.left};
  assign out_tlast = q_head.last;

`ifndef SYNTHESIS
  // A returning frame always finds room in the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r |-> (q_level != 2'd2 || pop))
    else $error("result queue overflow");

  // A non-empty read request starts a burst
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == ACT_READ && f_count != '0) |=> (state_r == ST_READ))
    else $error("read request did not start a burst");

  // Every load is followed by its write back
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_STORE && mem_we && mem_addr == $past(here_r)))
    else $error("missing write back after load");

  // The read position changes only on a move request
  assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_tuser == ACT_MOVE) |=> $stable(rp_r))
    else $error("read position changed without a move");

  // No frame read is issued once the burst is exhausted
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (remain_r != '0))
    else $error("burst state with nothing left to read");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo ring buffer with mid-side conversion.
// Runs a short table of hand-picked requests, then about 180 random ones
// biased toward recently written frames. Every read frame is checked
// against a behavioral model of the two sample stores and both positions.
// Random stalls on both channels are dropped for the last part of the run.
// ----------------------------------------------------------------------------
module tb
  import srb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam sample_t S_MAX      = 24'sh7FFFFF;
  localparam sample_t S_MIN      = 24'sh800000;
  localparam int      RAND_ITEMS = 180;
  localparam int      CALM_ITEMS = 40;
  localparam int      STALL_LIMIT = 4000;
  localparam int      TAIL_CYCLES = 16;

  typedef struct packed {
    logic [ACTION_W-1:0]        act;
    logic signed [OFFSET_W-1:0] off;
    logic [COUNT_W-1:0]         cnt;
    sample_t                    l;
    sample_t                    r;
    sample_t                    f;
    logic                       ch;
    logic                       typed;  // read frames must equal el/er below
    sample_t                    el;
    sample_t                    er;
  } req_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = '0;     // action
  // offset[11:0], count[18:12], left_sample[42:19], right_sample[66:43],
  // factor[90:67], channel[91], zero pad[95:92]
  logic [95:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;           // left_out[23:0], right_out[47:24]
  logic        out_tlast;

  // Model state
  sample_t           mem_left  [DEPTH];
  sample_t           mem_right [DEPTH];
  int                rd_pos;
  int                wr_pos;
  out_item_t         frames_due[$];
  int                mismatches    = 0;
  int                idle_cycles   = 0;
  bit                steady_phase  = 1'b0;

  req_row_t directed_rows [27] = '{
    '{ACT_READ,      0,   1, 0,     0,     0,     0, 1, 0,     0    },
    '{ACT_READ,  -2048,  64, 0,     0,     0,     0, 1, 0,     0    },
    '{ACT_WRITE,     0,   0, S_MAX, S_MIN, 0,     0, 0, 0,     0    },
    '{ACT_WRITE,     0,   0, S_MIN, S_MAX, 0,     0, 0, 0,     0    },
    '{ACT_WRITE,     0,   0, -1,    1,     0,     0, 0, 0,     0    },
    '{ACT_READ,      0,   1, 0,     0,     0,     0, 1, S_MAX, S_MIN},
    '{ACT_READ,      1,   1, 0,     0,     0,     0, 1, S_MIN, S_MAX},
    '{ACT_SCALE,     0,   0, 0,     0,     S_MAX, 1, 0, 0,     0    },
    '{ACT_SCALE,     0,   0, 0,     0,     S_MIN, 0, 0, 0,     0    },
    '{ACT_READ,      0,   1, 0,     0,     0,     0, 1, S_MAX, S_MAX},
    '{ACT_SCALE,     1,   0, 0,     0,     S_MIN, 0, 0, 0,     0    },
    '{ACT_READ,      1,   1, 0,     0,     0,     0, 1, S_MIN, S_MIN},
    '{ACT_SCALE,     2,   0, 0,     0,     0,     1, 0, 0,     0    },
    '{ACT_ENCODE,    2,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_READ,      2,   1, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_DECODE,    0,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_DECODE,    1,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_READ,      0,   2, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_ENCODE,    0,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_MOVE,      1,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_READ,     -1,   3, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_MOVE,  -2048,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_MOVE,   2047,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_READ,      0,   0, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_READ,   2047, 127, 0,     0,     0,     0, 0, 0,     0    },
    '{ACT_SPARE_6,   5,   9, S_MAX, S_MIN, S_MAX, 1, 0, 0,     0    },
    '{ACT_SPARE_7,  -5, 127, S_MIN, S_MAX, S_MIN, 0, 0, 0,     0    }
  };

  stereo_ring_buffer_mid_side_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int wrap_pos(input int x);
    int w;
    w = x % DEPTH;
    if (w < 0) begin
      w += DEPTH;
    end
    return w;
  endfunction

  function automatic sample_t clamp24(input longint v);
    if (v > longint'(S_MAX)) begin
      return S_MAX;
    end else if (v < longint'(S_MIN)) begin
      return S_MIN;
    end
    return sample_t'(v);
  endfunction

  // Mostly full-range samples, sometimes the corners
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return (($urandom_range(0, 1) == 1) ? sample_t'(0) : sample_t'(-1));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Present one request, hold it until accepted, then update the model
  task automatic issue_request(input logic [ACTION_W-1:0] act,
                               input logic signed [OFFSET_W-1:0] off,
                               input logic [COUNT_W-1:0] cnt,
                               input sample_t l, input sample_t r,
                               input sample_t f, input logic ch,
                               input bit typed, input sample_t el,
                               input sample_t er);
    int        here;
    int        n;
    int        a;
    longint    prod;
    longint    lv;
    longint    rv;
    out_item_t frame;
    if (!steady_phase && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0000, ch, f, r, l, cnt, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    here = wrap_pos(rd_pos + int'(off));
    case (act)
      ACT_WRITE: begin
        mem_left[wr_pos]  = l;
        mem_right[wr_pos] = r;
        wr_pos = wrap_pos(wr_pos + 1);
      end
      ACT_READ: begin
        n = (int'(cnt) > MAX_BURST) ? MAX_BURST : int'(cnt);
        for (int i = 0; i < n; i++) begin
          a = wrap_pos(rd_pos + int'(off) + i);
          frame.left  = typed ? el : mem_left[a];
          frame.right = typed ? er : mem_right[a];
          frame.last  = (i == n - 1);
          frames_due.push_back(frame);
        end
      end
      ACT_SCALE: begin
        // Q1.23 x Q4.20, round half up back to Q1.23
        lv   = ch ? longint'(mem_left[here]) : longint'(mem_right[here]);
        prod = lv * longint'(f) + (64'sd1 <<< (FRAC_W - 1));
        if (ch) begin
          mem_left[here] = clamp24(prod >>> FRAC_W);
        end else begin
          mem_right[here] = clamp24(prod >>> FRAC_W);
        end
      end
      ACT_ENCODE: begin
        lv = longint'(mem_left[here]);
        rv = longint'(mem_right[here]);
        mem_left[here]  = sample_t'((lv + rv) >>> 1);
        mem_right[here] = sample_t'((lv - rv) >>> 1);
      end
      ACT_DECODE: begin
        lv = longint'(mem_left[here]);
        rv = longint'(mem_right[here]);
        mem_left[here]  = clamp24(lv + rv);
        mem_right[here] = clamp24(lv - rv);
      end
      ACT_MOVE: begin
        rd_pos = here;
      end
      default: begin
        // spare codes leave everything untouched
      end
    endcase
  endtask

  // Result side: random back-pressure bursts, none in the steady phase
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each delivered frame with the oldest expected one
  always @(posedge clk) begin : frame_check
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: left_out %0d right_out %0d last %0b",
               $signed(out_tdata[23:0]), $signed(out_tdata[47:24]), out_tlast);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (out_tdata[23:0] !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left,
                 $signed(out_tdata[23:0]));
          mismatches++;
        end
        if (out_tdata[47:24] !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right,
                 $signed(out_tdata[47:24]));
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int                         n_sent;
    logic [ACTION_W-1:0]        act;
    logic signed [OFFSET_W-1:0] off;
    logic [COUNT_W-1:0]         cnt;
    sample_t                    l;
    sample_t                    r;
    sample_t                    f;
    logic                       ch;
    int                         sel;

    foreach (mem_left[k]) begin
      mem_left[k]  = '0;
      mem_right[k] = '0;
    end
    rd_pos = 0;
    wr_pos = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-picked requests
    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].act, directed_rows[k].off, directed_rows[k].cnt,
                    directed_rows[k].l, directed_rows[k].r, directed_rows[k].f,
                    directed_rows[k].ch, directed_rows[k].typed,
                    directed_rows[k].el, directed_rows[k].er);
    end

    // Random requests; spare codes do not count
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      if (n_sent == RAND_ITEMS / 2) begin
        // hold the sender until every frame has drained
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0) @(posedge clk);
      end
      steady_phase = (n_sent >= RAND_ITEMS - CALM_ITEMS);

      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        act = ACT_WRITE;
      end else if (sel < 60) begin
        act = ACT_READ;
      end else if (sel < 70) begin
        act = ACT_SCALE;
      end else if (sel < 78) begin
        act = ACT_ENCODE;
      end else if (sel < 86) begin
        act = ACT_DECODE;
      end else if (sel < 94) begin
        act = ACT_MOVE;
      end else begin
        act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_6 : ACT_SPARE_7;
      end

      // often aim at the frames written last
      case ($urandom_range(0, 9))
        0, 1:       off = OFFSET_W'($urandom);
        2, 3, 4, 5: off = OFFSET_W'(wr_pos - rd_pos - int'($urandom_range(1, 8)));
        default:    off = OFFSET_W'(int'($urandom_range(0, 32)) - 16);
      endcase

      case ($urandom_range(0, 19))
        0:       cnt = '0;
        1:       cnt = COUNT_W'($urandom_range(65, 127));
        2, 3:    cnt = COUNT_W'($urandom_range(9, 64));
        default: cnt = COUNT_W'($urandom_range(1, 8));
      endcase

      l = pick_sample();
      r = pick_sample();
      case ($urandom_range(0, 9))
        0:          f = S_MAX;
        1:          f = S_MIN;
        2, 3, 4, 5: f = sample_t'(int'($urandom_range(0, 32'h200000)) - 32'sh100000);
        default:    f = sample_t'($urandom);
      endcase
      ch = 1'($urandom_range(0, 1));

      issue_request(act, off, cnt, l, r, f, ch, 1'b0, '0, '0);
      if (act != ACT_SPARE_6 && act != ACT_SPARE_7) begin
        n_sent++;
      end
    end
    in_tvalid <= 1'b0;

    // Drain and give stray frames a chance to show up
    while (frames_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
